@@ rtl/core/bgtm_pkg.sv @@
// Shared types, widths and constants of the battery gauge trimmed-mean block.
// Used by every module in rtl/core; depends on nothing else.
package bgtm_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int USED_W    = 12;
  localparam int SUM_W     = 16;
  localparam int MV_W      = 16;
  localparam int LEVEL_W   = 8;
  localparam int REFMV_W   = 12;
  localparam int WARM_W    = 5;

  // Divider operand widths: the largest dividend is 2 * ref_mv * avg_batt.
  localparam int DIVIDEND_W = 2 * USED_W + 1;
  localparam int DIVISOR_W  = 16;

  // Defaults for the top-level parameters.
  localparam int DEF_BURST_LEN     = 10;
  localparam int DEF_WARMUP_BURSTS = 16;

  // Configuration port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_REF_MV = 1'b0;
  localparam logic [REFMV_W-1:0]   REFMV_RESET = 12'd1224;

  // Arithmetic constants.
  localparam logic [SAMPLE_W-1:0]  FOLD_LIMIT   = 16'd4096;
  localparam logic [MV_W-1:0]      MV_MAX       = 16'hFFFF;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 8'hFF;

  // Reciprocal multiplication for the divisions by constants. Each reciprocal is
  // rounded up, and the shift is large enough that the quotient is exact over the
  // whole numerator range (trimmed sums below 2^16, other numerators below 2^20).
  localparam int RECIP_W      = 21;
  localparam int AVG_SHIFT    = 20;
  localparam int SNUM_W       = 20;
  localparam int SMOOTH_SHIFT = 24;
  localparam logic [RECIP_W-1:0] SMOOTH_RECIP = 21'd1677722;
  // Level reciprocal already carries the factor 15, so one product gives 15*sv/1000.
  localparam int LVL_RECIP_W  = 24;
  localparam int LEVEL_SHIFT  = 30;
  localparam logic [LVL_RECIP_W-1:0] LEVEL_RECIP = 24'd16106130;

  // One finished burst as it goes to the output register.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [MV_W-1:0]    mv;
    logic               err;
  } result_t;

  // Large raw samples are folded down by four bits.
  function automatic logic [USED_W-1:0] fold_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] v;
    v = (raw >= FOLD_LIMIT) ? (raw >> 4) : raw;
    return v[USED_W-1:0];
  endfunction

endpackage

@@ rtl/core/bgtm_lane.sv @@
// One channel lane: folds samples and keeps the burst sum, maximum and minimum.
// Depends on bgtm_pkg.
module bgtm_lane
  import bgtm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                first_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic [SUM_W-1:0]    trim_o
);

  logic [USED_W-1:0] s;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [USED_W-1:0] max_q, max_d;
  logic [USED_W-1:0] min_q, min_d;

  assign s = fold_sample(sample_i);

  // The first scan of a burst restarts the sum and loads both extremes.
  always_comb begin
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    if (accept_i) begin
      if (first_i) begin
        sum_d = SUM_W'(s);
        max_d = s;
        min_d = s;
      end else begin
        sum_d = sum_q + SUM_W'(s);
        if (s > max_q) max_d = s;
        if (s < min_q) min_d = s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      max_q <= '0;
      min_q <= '0;
    end else begin
      sum_q <= sum_d;
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  // The extremes are part of the sum, so this never goes below zero.
  assign trim_o = sum_q - SUM_W'(max_q) - SUM_W'(min_q);

endmodule

@@ rtl/core/bgtm_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on bgtm_pkg for default widths.
module bgtm_divider
  import bgtm_pkg::*;
#(
  parameter int DividendW = DIVIDEND_W,
  parameter int DivisorW  = DIVISOR_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);

  localparam int CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  dsr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 run_q;
  logic                 done_q;

  logic [DivisorW:0]    shifted;
  logic [DivisorW+1:0]  diff;
  logic                 borrow;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign borrow  = diff[DivisorW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DividendW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      if (borrow) begin
        rem_q <= shifted[DivisorW-1:0];
        quo_q <= {quo_q[DividendW-2:0], 1'b0};
      end else begin
        rem_q <= diff[DivisorW-1:0];
        quo_q <= {quo_q[DividendW-2:0], 1'b1};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/bgtm_merge.sv @@
// End-of-burst merge: averages, millivolt ratio, smoothing and level.
// Depends on bgtm_pkg and on bgtm_divider, which computes the millivolt ratio.
module bgtm_merge
  import bgtm_pkg::*;
#(
  parameter int BURST_LEN     = DEF_BURST_LEN,
  parameter int WARMUP_BURSTS = DEF_WARMUP_BURSTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   ref_trim_i,
  input  logic [SUM_W-1:0]   batt_trim_i,
  input  logic [REFMV_W-1:0] ref_mv_i,
  input  logic               out_free_i,
  output logic               busy_o,
  output logic               load_o,
  output result_t            result_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_AVG    = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_MV_GO  = 8'b0000_1000,
    ST_MV     = 8'b0001_0000,
    ST_SMOOTH = 8'b0010_0000,
    ST_LEVEL  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } merge_state_e;

  localparam int AMUL_W     = SUM_W + RECIP_W;
  localparam int SMUL_W     = SNUM_W + RECIP_W;
  localparam int LMUL_W     = MV_W + LVL_RECIP_W;
  localparam int LVL_RAW_W  = LMUL_W - LEVEL_SHIFT;

  // Rounded-up reciprocal of the number of kept scans.
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << AVG_SHIFT) + BURST_LEN - 3) / (BURST_LEN - 2));

  merge_state_e state_q, state_d;
  logic [USED_W-1:0]     avg_ref_q, avg_ref_d;
  logic [USED_W-1:0]     avg_batt_q, avg_batt_d;
  logic [DIVIDEND_W-1:0] prod_q, prod_d;
  logic [SNUM_W-1:0]     num_q, num_d;
  logic [MV_W-1:0]       sv_q, sv_d;
  logic [WARM_W-1:0]     warm_q, warm_d;
  logic                  err_q, err_d;
  logic [LEVEL_W-1:0]    level_q, level_d;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;

  logic [AMUL_W-1:0]     ref_avg_full;
  logic [AMUL_W-1:0]     batt_avg_full;
  logic [2*USED_W-1:0]   mul_full;
  logic [MV_W-1:0]       mv_sat;
  logic [SNUM_W-1:0]     smooth_num;
  logic [SMUL_W-1:0]     smooth_full;
  logic [LMUL_W-1:0]     level_full;
  logic [LVL_RAW_W-1:0]  level_raw;

  // Trimmed averages by reciprocal multiplication.
  assign ref_avg_full  = AMUL_W'(ref_trim_i) * AMUL_W'(AVG_RECIP);
  assign batt_avg_full = AMUL_W'(batt_trim_i) * AMUL_W'(AVG_RECIP);

  // The only product of two variables: reference voltage times battery average.
  assign mul_full = {{USED_W{1'b0}}, ref_mv_i} * {{USED_W{1'b0}}, avg_batt_q};

  // Saturated millivolt quotient.
  assign mv_sat = (div_quo > DIVIDEND_W'(MV_MAX)) ? MV_MAX : div_quo[MV_W-1:0];

  // Smoothing numerator 9*sv + mv, then the division by ten.
  assign smooth_num  = (SNUM_W'(sv_q) << 3) + SNUM_W'(sv_q) + SNUM_W'(mv_sat);
  assign smooth_full = SMUL_W'(num_q) * SMUL_W'(SMOOTH_RECIP);

  // Level 15*sv/1000 in one product.
  assign level_full = LMUL_W'(sv_q) * LMUL_W'(LEVEL_RECIP);
  assign level_raw  = level_full[LMUL_W-1:LEVEL_SHIFT];

  // The divider only ever sees the millivolt ratio.
  assign div_dividend = prod_q;
  assign div_divisor  = DIVISOR_W'(avg_ref_q);

  // Sequencer for one finished burst.
  always_comb begin
    state_d    = state_q;
    avg_ref_d  = avg_ref_q;
    avg_batt_d = avg_batt_q;
    prod_d     = prod_q;
    num_d      = num_q;
    sv_d       = sv_q;
    warm_d     = warm_q;
    err_d      = err_q;
    level_d    = level_q;
    div_start  = 1'b0;
    load_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_AVG;
      end
      ST_AVG: begin
        avg_ref_d  = ref_avg_full[AVG_SHIFT +: USED_W];
        avg_batt_d = batt_avg_full[AVG_SHIFT +: USED_W];
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        err_d  = (avg_ref_q == '0);
        prod_d = {mul_full, 1'b0};
        // A zero reference average leaves the smoothed value alone.
        state_d = (avg_ref_q == '0) ? ST_LEVEL : ST_MV_GO;
      end
      ST_MV_GO: begin
        div_start = 1'b1;
        state_d   = ST_MV;
      end
      ST_MV: begin
        if (div_done) begin
          if (warm_q != '0) begin
            warm_d  = warm_q - 1'b1;
            sv_d    = mv_sat;
            state_d = ST_LEVEL;
          end else begin
            num_d   = smooth_num;
            state_d = ST_SMOOTH;
          end
        end
      end
      ST_SMOOTH: begin
        sv_d    = smooth_full[SMOOTH_SHIFT +: MV_W];
        state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        level_d = (level_raw > LVL_RAW_W'(LEVEL_MAX)) ? LEVEL_MAX : level_raw[LEVEL_W-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          load_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sv_q    <= '0;
      warm_q  <= WARM_W'(WARMUP_BURSTS);
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sv_q    <= sv_d;
      warm_q  <= warm_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_ref_q  <= avg_ref_d;
    avg_batt_q <= avg_batt_d;
    prod_q     <= prod_d;
    num_q      <= num_d;
    level_q    <= level_d;
  end

  bgtm_divider #(
    .DividendW (DIVIDEND_W),
    .DivisorW  (DIVISOR_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign result_o.level = level_q;
  assign result_o.mv    = sv_q;
  assign result_o.err   = err_q;

endmodule

@@ rtl/core/battery_gauge_trimmed_mean.sv @@
// Battery gauge: two sample lanes, a merge stage and an output register.
// Scans are taken one per cycle within a burst; after the last scan of a burst the input
// stalls while the merge runs: averages, ratio divider, smoothing and level; warm-up skips
// smoothing, and a zero reference skips the divider and smoothing. A still-full output
// register delays the result, and the input stays stalled until the result is loaded.
// Asynchronous active-low reset clears the control state, reloads the warm-up count and restores the register.
module battery_gauge_trimmed_mean
  import bgtm_pkg::*;
#(
  parameter int BURST_LEN     = DEF_BURST_LEN,
  parameter int WARMUP_BURSTS = DEF_WARMUP_BURSTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Scan requests.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] vref_sample_i,
  input  logic [SAMPLE_W-1:0] batt_sample_i,
  // Result requests.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LEVEL_W-1:0]  battery_level_o,
  output logic [MV_W-1:0]     smoothed_millivolts_o,
  output logic                ref_error_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int CntW = $clog2(BURST_LEN);

  logic [CntW-1:0]    scan_cnt_q;
  logic               scan_acc;
  logic               scan_first;
  logic               scan_last;
  logic [REFMV_W-1:0] ref_mv_q;
  logic [SUM_W-1:0]   ref_trim;
  logic [SUM_W-1:0]   batt_trim;
  logic               merge_busy;
  logic               merge_load;
  logic               out_free;
  result_t            merge_res;
  logic               out_valid_q;
  result_t            out_q;
  logic [REG_IDX_W-1:0] reg_idx;

  assign in_ready_o = !merge_busy;
  assign scan_acc   = in_valid_i && in_ready_o;
  assign scan_first = (scan_cnt_q == '0);
  assign scan_last  = (scan_cnt_q == CntW'(BURST_LEN - 1));

  // Scan counter within a burst.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
    end else if (scan_acc) begin
      scan_cnt_q <= scan_last ? '0 : scan_cnt_q + 1'b1;
    end
  end

  // Configuration register, written on the access phase of a write.
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_REF_MV) ? PDATA_W'(ref_mv_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mv_q <= REFMV_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_REF_MV)) begin
      ref_mv_q <= pwdata[REFMV_W-1:0];
    end
  end

  bgtm_lane u_lane_ref (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (scan_acc),
    .first_i  (scan_first),
    .sample_i (vref_sample_i),
    .trim_o   (ref_trim)
  );

  bgtm_lane u_lane_batt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (scan_acc),
    .first_i  (scan_first),
    .sample_i (batt_sample_i),
    .trim_o   (batt_trim)
  );

  bgtm_merge #(
    .BURST_LEN     (BURST_LEN),
    .WARMUP_BURSTS (WARMUP_BURSTS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_acc && scan_last),
    .ref_trim_i  (ref_trim),
    .batt_trim_i (batt_trim),
    .ref_mv_i    (ref_mv_q),
    .out_free_i  (out_free),
    .busy_o      (merge_busy),
    .load_o      (merge_load),
    .result_o    (merge_res)
  );

  // Output register decouples the merge stage from the consumer.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (merge_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_load) out_q <= merge_res;
  end

  assign out_valid_o           = out_valid_q;
  assign battery_level_o       = out_q.level;
  assign smoothed_millivolts_o = out_q.mv;
  assign ref_error_o           = out_q.err;

  // The last scan of a burst stalls the input while the merge runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_acc && scan_last) |=> !in_ready_o)
    else $error("input not stalled after the last scan of a burst");

  // A pending result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (merge_load && out_valid_q) |-> out_ready_i)
    else $error("result register overwritten while still pending");

  // The scan counter stays inside the burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cnt_q <= CntW'(BURST_LEN - 1))
    else $error("scan counter ran past the burst length");

endmodule

@@ test/tb_battery_gauge_trimmed_mean.sv @@
// Self-checking testbench for battery_gauge_trimmed_mean: directed bursts, then random bursts.
// Depends on bgtm_pkg and the battery_gauge_trimmed_mean RTL; needs nothing else.
module tb_battery_gauge_trimmed_mean;
  import bgtm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BURST_SCANS     = DEF_BURST_LEN;
  localparam int WARMUP_COUNT    = DEF_WARMUP_BURSTS;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int BURSTS_PER_PASS = 10;
  localparam int N_DIRECTED      = 10;
  localparam int REPORT_LIMIT    = 10;

  // How the samples of one channel vary over a burst.
  typedef enum int {
    PAT_STEADY,
    PAT_NOISY,
    PAT_SPIKE,
    PAT_RAW,
    PAT_FOLDED
  } scan_pattern_e;

  // One directed burst: register value, sample shape per channel, optional known result.
  typedef struct {
    logic [REFMV_W-1:0] ref_mv;
    scan_pattern_e      vref_pat;
    int                 vref_base;
    scan_pattern_e      batt_pat;
    int                 batt_base;
    bit                 typed;
    result_t            want;
  } burst_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] vref_sample_i = '0;
  logic [SAMPLE_W-1:0] batt_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [LEVEL_W-1:0]  battery_level_o;
  logic [MV_W-1:0]     smoothed_millivolts_o;
  logic                ref_error_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [PDATA_W-1:0]  pwdata        = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Gauge shadow state.
  logic [REFMV_W-1:0] cfg_ref_mv;
  logic [3:0]         scan_idx;
  logic [SUM_W-1:0]   ref_total, batt_total;
  logic [USED_W-1:0]  ref_hi, ref_lo, batt_hi, batt_lo;
  logic [MV_W-1:0]    smooth_mv;
  logic [WARM_W-1:0]  warm_left;

  result_t expected_readings[$];
  int      bad_readings  = 0;
  int      send_idle_pct = 12;
  int      recv_idle_pct = 84;
  int      stall_cycles;

  burst_row_t directed_bursts [N_DIRECTED] = '{
    '{12'd1224, PAT_STEADY, 1000,  PAT_STEADY, 500,   1'b1, '{8'd18,  16'd1224,  1'b0}},
    // Reference average of zero: the burst is dropped and flagged.
    '{12'd1224, PAT_STEADY, 0,     PAT_STEADY, 500,   1'b1, '{8'd18,  16'd1224,  1'b1}},
    // Largest raw samples fold down to 4095.
    '{12'd1224, PAT_STEADY, 65535, PAT_STEADY, 65535, 1'b1, '{8'd36,  16'd2448,  1'b0}},
    // Tiny reference: the quotient saturates.
    '{12'd1224, PAT_STEADY, 1,     PAT_STEADY, 4095,  1'b1, '{8'd255, 16'hFFFF,  1'b0}},
    // Just at the folding threshold.
    '{12'd1224, PAT_STEADY, 4096,  PAT_STEADY, 4095,  1'b0, '{8'd0,   16'd0,     1'b0}},
    '{12'd1224, PAT_STEADY, 4095,  PAT_STEADY, 0,     1'b1, '{8'd0,   16'd0,     1'b0}},
    // Zero reference register gives zero millivolts.
    '{12'd0,    PAT_STEADY, 1000,  PAT_STEADY, 2000,  1'b1, '{8'd0,   16'd0,     1'b0}},
    '{12'd4095, PAT_NOISY,  1000,  PAT_NOISY,  2000,  1'b0, '{8'd0,   16'd0,     1'b0}},
    // A lone reference spike is trimmed away, so the average is zero.
    '{12'd4095, PAT_SPIKE,  3000,  PAT_NOISY,  1500,  1'b0, '{8'd0,   16'd0,     1'b0}},
    '{12'd4095, PAT_RAW,    0,     PAT_RAW,    0,     1'b0, '{8'd0,   16'd0,     1'b0}}
  };

  battery_gauge_trimmed_mean #(
    .BURST_LEN     (BURST_SCANS),
    .WARMUP_BURSTS (WARMUP_COUNT)
  ) uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .vref_sample_i         (vref_sample_i),
    .batt_sample_i         (batt_sample_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .battery_level_o       (battery_level_o),
    .smoothed_millivolts_o (smoothed_millivolts_o),
    .ref_error_o           (ref_error_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    bad_readings++;
    if (bad_readings <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // Advance the gauge shadow by one scan; a finished burst yields one reading.
  task automatic trimmed_mean_step(input logic [SAMPLE_W-1:0] vraw,
                                   input logic [SAMPLE_W-1:0] braw,
                                   output bit produced, output result_t res);
    logic [USED_W-1:0] r, b;
    int unsigned avg_r, avg_b, mv, lvl;
    r = (vraw >= 16'd4096) ? vraw[15:4] : vraw[USED_W-1:0];
    b = (braw >= 16'd4096) ? braw[15:4] : braw[USED_W-1:0];
    produced = 1'b0;
    res = '0;
    ref_total  = ref_total + r;
    batt_total = batt_total + b;
    if (scan_idx == 0) begin
      ref_hi  = r;
      ref_lo  = r;
      batt_hi = b;
      batt_lo = b;
    end else begin
      if (r > ref_hi) ref_hi = r;
      if (r < ref_lo) ref_lo = r;
      if (b > batt_hi) batt_hi = b;
      if (b < batt_lo) batt_lo = b;
    end
    if (int'(scan_idx) + 1 < BURST_SCANS) begin
      scan_idx = scan_idx + 4'd1;
      return;
    end

    // End of burst: trim both extremes and average the rest.
    avg_r = (32'(ref_total) - 32'(ref_hi) - 32'(ref_lo)) / (BURST_SCANS - 2);
    avg_b = (32'(batt_total) - 32'(batt_hi) - 32'(batt_lo)) / (BURST_SCANS - 2);
    scan_idx   = '0;
    ref_total  = '0;
    batt_total = '0;
    ref_hi     = '0;
    ref_lo     = '0;
    batt_hi    = '0;
    batt_lo    = '0;

    if (avg_r == 0) begin
      res.err = 1'b1;
    end else begin
      mv = (32'd2 * 32'(cfg_ref_mv) * avg_b) / avg_r;
      if (mv > 32'd65535) mv = 32'd65535;
      if (warm_left != 0) begin
        warm_left = warm_left - 5'd1;
        smooth_mv = mv[MV_W-1:0];
      end else begin
        smooth_mv = 16'((32'd9 * 32'(smooth_mv) + mv) / 32'd10);
      end
    end
    lvl = (32'(smooth_mv) * 32'd15) / 32'd1000;
    res.level = (lvl > 32'd255) ? 8'hFF : lvl[LEVEL_W-1:0];
    res.mv    = smooth_mv;
    produced  = 1'b1;
  endtask

  function automatic logic [SAMPLE_W-1:0] scan_value(input scan_pattern_e pat, input int base,
                                                     input int idx);
    int v;
    case (pat)
      PAT_STEADY: v = base;
      PAT_NOISY: begin
        v = base + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      PAT_SPIKE:  v = (idx == 3) ? base : 0;
      PAT_RAW:    v = int'($urandom_range(0, 65535));
      default:    v = int'($urandom_range(4096, 65535));
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic scan_pattern_e pick_pattern();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return PAT_NOISY;
    if (r < 65) return PAT_STEADY;
    if (r < 80) return PAT_RAW;
    if (r < 90) return PAT_FOLDED;
    return PAT_SPIKE;
  endfunction

  // Present one scan request, with an optional gap first, and wait until it is taken.
  task automatic send_scan(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] b,
                           input bit typed, input result_t want);
    bit      produced;
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vref_sample_i <= v;
    batt_sample_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    trimmed_mean_step(v, b, produced, res);
    if (produced) begin
      expected_readings.push_back(typed ? want : res);
    end
  endtask

  task automatic send_burst(input scan_pattern_e vpat, input int vbase,
                            input scan_pattern_e bpat, input int bbase,
                            input bit typed, input result_t want);
    for (int i = 0; i < BURST_SCANS; i++) begin
      send_scan(scan_value(vpat, vbase, i), scan_value(bpat, bbase, i), typed, want);
    end
  endtask

  // Stop sending, wait for all readings, let the block settle, then write and read back.
  task automatic set_ref_mv(input logic [REFMV_W-1:0] value);
    logic [PADDR_W-1:0] addr;
    addr = {REG_REF_MV, 2'b00};
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel       <= 1'b1;
    penable    <= 1'b0;
    pwrite     <= 1'b1;
    paddr      <= addr;
    pwdata     <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_ref_mv = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(value)) begin
      report($sformatf("ref_millivolts readback: expected %0d, got %0d", value, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk_i) begin
    result_t want, got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{battery_level_o, smoothed_millivolts_o, ref_error_o};
        if (expected_readings.size() == 0) begin
          report($sformatf("unexpected reading: level %0d mv %0d err %0b",
                           got.level, got.mv, got.err));
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            report($sformatf({"reading: expected level %0d mv %0d err %0b, ",
                              "got level %0d mv %0d err %0b"},
                             want.level, want.mv, want.err, got.level, got.mv, got.err));
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no accepted request on any port.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("battery_gauge_trimmed_mean: mismatch");
    $finish;
  end

  initial begin
    int vbase, bbase;
    scan_pattern_e vpat, bpat;
    cfg_ref_mv = REFMV_RESET;
    scan_idx   = '0;
    ref_total  = '0;
    batt_total = '0;
    ref_hi     = '0;
    ref_lo     = '0;
    batt_hi    = '0;
    batt_lo    = '0;
    smooth_mv  = '0;
    warm_left  = WARM_W'(WARMUP_COUNT);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed bursts.
    foreach (directed_bursts[i]) begin
      if (directed_bursts[i].ref_mv != cfg_ref_mv) begin
        set_ref_mv(directed_bursts[i].ref_mv);
      end
      send_burst(directed_bursts[i].vref_pat, directed_bursts[i].vref_base,
                 directed_bursts[i].batt_pat, directed_bursts[i].batt_base,
                 directed_bursts[i].typed, directed_bursts[i].want);
    end

    // Random bursts in three passes with different idling and register values.
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: set_ref_mv(12'd1);
        1: set_ref_mv(12'd4095);
        default: set_ref_mv(REFMV_W'($urandom_range(1, 4095)));
      endcase
      send_idle_pct = (pass == 0) ? 12 : (pass == 1) ? 84 : 0;
      recv_idle_pct = (pass == 0) ? 84 : (pass == 1) ? 12 : 0;
      for (int n = 0; n < BURSTS_PER_PASS; n++) begin
        vpat  = pick_pattern();
        bpat  = pick_pattern();
        vbase = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(20, 4075));
        bbase = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(20, 4075));
        send_burst(vpat, vbase, bpat, bbase, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bad_readings == 0 && expected_readings.size() == 0) begin
      $display("battery_gauge_trimmed_mean: match");
    end else begin
      $display("battery_gauge_trimmed_mean: mismatch");
    end
    $finish;
  end

endmodule
